// ===== design/ascd_pkg.sv =====
package ascd_pkg;

  localparam int unsigned MaskW = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 6;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_CAMERA_COUNT  = 2'd0,
    REG_ACTIVE_LIMIT  = 2'd1,
    REG_COOLDOWN_TIME = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] age;
  } lane_age_t;

endpackage

// ===== design/ascd_lane.sv =====
module ascd_lane (
  input  logic                             clk,
  input  logic                             wr,
  input  logic [ascd_pkg::TimeW-1:0]       wr_time,
  input  logic                             clr,
  input  logic [ascd_pkg::TimeW-1:0]       now,
  input  logic [ascd_pkg::TimeW-1:0]       cooldown,
  input  logic                             rst,
  output logic                             fresh,
  output ascd_pkg::lane_age_t              age_info
);

  logic [ascd_pkg::TimeW-1:0] seen_time;
  logic                       seen_valid;
  logic [ascd_pkg::TimeW-1:0] age;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      seen_valid <= 1'b0;
    end else if (wr) begin
      seen_valid <= 1'b1;
    end
    if (wr) begin
      seen_time <= wr_time;
    end
  end

  assign age = now - seen_time;
  assign fresh = seen_valid && (age < cooldown);
  assign age_info.valid = seen_valid;
  assign age_info.age = age;

endmodule

// ===== design/ascd_pick.sv =====
module ascd_pick #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [SLOTS-1:0]                cand,
  input  ascd_pkg::lane_age_t             ages [SLOTS],
  output logic                            done,
  output logic                            found,
  output logic [$clog2(SLOTS+1)-1:0]      victim
);

  localparam int unsigned IdxW = $clog2(SLOTS+1);
  localparam int unsigned SelW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic                       busy;
  logic [SelW-1:0]            idx;
  logic [ascd_pkg::TimeW-1:0] best;
  logic [ascd_pkg::TimeW-1:0] cur_age;
  logic                       cur_ok;

  assign cur_ok  = cand[idx] && ages[idx].valid;
  assign cur_age = ages[idx].age;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy   <= 1'b1;
        idx    <= '0;
        best   <= '0;
        found  <= 1'b0;
        victim <= '0;
      end else if (busy) begin
        if (cur_ok && cur_age > best) begin
          best   <= cur_age;
          victim <= IdxW'(idx);
          found  <= 1'b1;
        end
        if (idx == SelW'(SLOTS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/active_set_cooldown_evict.sv =====
// One item per start pulse, busy while it runs. A pass steps through each camera in range
// with its detect bit set, and each such camera that meets a full set adds one eviction
// scan over all CAMERA_SLOTS slots; the worst case is CAMERA_SLOTS scans. The result
// shows for one cycle on valid and cannot be held off.
module active_set_cooldown_evict #(
  parameter int unsigned CAMERA_SLOTS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ascd_pkg::DataW-1:0]     cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [ascd_pkg::MaskW-1:0]     detect_mask,
  input  logic [ascd_pkg::TimeW-1:0]     now_time,
  output logic                           valid,
  output logic [ascd_pkg::MaskW-1:0]     active_cams,
  output logic [ascd_pkg::MaskW-1:0]     activated_mask,
  output logic [ascd_pkg::MaskW-1:0]     deactivated_mask,
  output logic                           changed
);

  localparam int unsigned IdxW = $clog2(CAMERA_SLOTS+1);

  typedef enum logic [2:0] {S_IDLE, S_AGE, S_REQ, S_WAIT, S_DONE} state_t;

  state_t state;
  logic [ascd_pkg::CfgW-1:0]  camera_count;
  logic [ascd_pkg::CfgW-1:0]  active_limit;
  logic [ascd_pkg::TimeW-1:0] cooldown_time;
  logic [CAMERA_SLOTS-1:0]    active_set;
  logic [CAMERA_SLOTS-1:0]    still, act, deact, pend;
  logic [ascd_pkg::TimeW-1:0] now;
  logic [CAMERA_SLOTS-1:0]    fresh;
  logic [CAMERA_SLOTS-1:0]    in_range;
  logic [CAMERA_SLOTS-1:0]    req_mask;
  logic [CAMERA_SLOTS-1:0]    req_bit;
  logic [CAMERA_SLOTS-1:0]    pend_next;
  logic [IdxW-1:0]            still_cnt;
  logic                       pick_go, pick_done, pick_found;
  logic [IdxW-1:0]            victim;
  logic [CAMERA_SLOTS-1:0]    victim_bit;
  ascd_pkg::lane_age_t        ages [CAMERA_SLOTS];
  logic                       accept;
  logic                       under_limit;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  always_comb begin
    for (int i = 0; i < CAMERA_SLOTS; i++) begin
      in_range[i] = (7'(i) < {1'b0, camera_count});
    end
  end
  assign req_mask = detect_mask[CAMERA_SLOTS-1:0] & in_range;

  for (genvar g = 0; g < CAMERA_SLOTS; g++) begin : g_lane
    ascd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .wr       (accept && req_mask[g]),
      .wr_time  (now_time),
      .clr      (1'b0),
      .now      (now),
      .cooldown (cooldown_time),
      .fresh    (fresh[g]),
      .age_info (ages[g])
    );
  end

  ascd_pick #(.SLOTS(CAMERA_SLOTS)) u_pick (
    .clk    (clk),
    .rst    (rst),
    .go     (pick_go),
    .cand   (still),
    .ages   (ages),
    .done   (pick_done),
    .found  (pick_found),
    .victim (victim)
  );

  assign req_bit   = pend & (~pend + 1'b1);
  assign pend_next = pend & ~req_bit;

  always_comb begin
    still_cnt = '0;
    for (int i = 0; i < CAMERA_SLOTS; i++) begin
      still_cnt = still_cnt + IdxW'(still[i]);
    end
  end

  always_comb begin
    victim_bit = '0;
    for (int i = 0; i < CAMERA_SLOTS; i++) begin
      victim_bit[i] = (victim == IdxW'(i));
    end
  end

  assign under_limit = (7'(still_cnt) < {1'b0, active_limit});

  assign pick_go = (state == S_REQ) && (pend != '0) && ((req_bit & still) == '0) &&
                   !under_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      camera_count  <= 6'd25;
      active_limit  <= 6'd4;
      cooldown_time <= 32'd5000;
      active_set    <= '0;
      valid         <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ascd_pkg::REG_CAMERA_COUNT:  camera_count  <= cfg_data[ascd_pkg::CfgW-1:0];
          ascd_pkg::REG_ACTIVE_LIMIT:  active_limit  <= cfg_data[ascd_pkg::CfgW-1:0];
          ascd_pkg::REG_COOLDOWN_TIME: cooldown_time <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            now   <= now_time;
            pend  <= req_mask;
            state <= S_AGE;
          end
        end
        S_AGE: begin
          still <= active_set & fresh;
          deact <= active_set & ~fresh;
          act   <= '0;
          state <= S_REQ;
        end
        S_REQ: begin
          if (pend == '0) begin
            state <= S_DONE;
          end else if ((req_bit & still) != '0) begin
            pend <= pend_next;
          end else if (under_limit) begin
            still <= still | req_bit;
            act   <= act | req_bit;
            pend  <= pend_next;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (pick_done) begin
            if (pick_found) begin
              still <= (still & ~victim_bit) | req_bit;
              deact <= deact | victim_bit;
              act   <= act | req_bit;
            end
            pend  <= pend_next;
            state <= S_REQ;
          end
        end
        S_DONE: begin
          active_set       <= still;
          active_cams      <= ascd_pkg::MaskW'(still);
          activated_mask   <= ascd_pkg::MaskW'(act);
          deactivated_mask <= ascd_pkg::MaskW'(deact);
          changed          <= (act != '0) || (deact != '0);
          valid            <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_active_set_cooldown_evict.sv =====
`timescale 1ns / 100ps

module tb_active_set_cooldown_evict;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 1200;
  localparam int unsigned RandItems = 1850;
  localparam int unsigned CalmItems = 200;

  typedef struct packed {
    logic [ascd_pkg::MaskW-1:0] active;
    logic [ascd_pkg::MaskW-1:0] joined;
    logic [ascd_pkg::MaskW-1:0] dropped;
    logic                       changed;
  } outcome_t;

  typedef struct {
    bit                         is_cfg;
    logic [1:0]                 idx;
    logic [ascd_pkg::DataW-1:0] data;
    logic [ascd_pkg::MaskW-1:0] det;
    logic [ascd_pkg::TimeW-1:0] now;
    bit                         typed;
    outcome_t                   want;
  } stim_row_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [1:0]                 cfg_index;
  logic [ascd_pkg::DataW-1:0] cfg_data;
  logic                       start;
  logic                       busy;
  logic [ascd_pkg::MaskW-1:0] detect_mask;
  logic [ascd_pkg::TimeW-1:0] now_time;
  logic                       valid;
  logic [ascd_pkg::MaskW-1:0] active_cams;
  logic [ascd_pkg::MaskW-1:0] activated_mask;
  logic [ascd_pkg::MaskW-1:0] deactivated_mask;
  logic                       changed;

  active_set_cooldown_evict u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .detect_mask(detect_mask), .now_time(now_time),
    .valid(valid), .active_cams(active_cams), .activated_mask(activated_mask),
    .deactivated_mask(deactivated_mask), .changed(changed)
  );

  logic [ascd_pkg::TimeW-1:0] cam_seen [32];
  bit                         cam_seen_ok [32];
  logic [ascd_pkg::MaskW-1:0] cam_active;
  logic [5:0]                 cam_count;
  logic [5:0]                 cam_limit;
  logic [ascd_pkg::TimeW-1:0] cam_cooldown;

  outcome_t   outcome_q[$];
  stim_row_t  stim_tbl[$];
  int         mismatches;
  int         idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pop_count(logic [31:0] m);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 32; i++) n += m[i];
    return n;
  endfunction

  function automatic outcome_t evaluate_batch(logic [ascd_pkg::MaskW-1:0] det,
                                              logic [ascd_pkg::TimeW-1:0] now);
    outcome_t                   r;
    int unsigned                ncam;
    logic [ascd_pkg::MaskW-1:0] keep;
    logic [ascd_pkg::MaskW-1:0] on;
    logic [ascd_pkg::MaskW-1:0] off;
    logic [ascd_pkg::TimeW-1:0] best;
    logic [ascd_pkg::TimeW-1:0] age;
    int                         victim;
    ncam = (cam_count > 32) ? 32 : cam_count;
    keep = '0;
    on = '0;
    off = '0;
    for (int i = 0; i < ncam; i++) begin
      if (det[i]) begin
        cam_seen[i] = now;
        cam_seen_ok[i] = 1'b1;
      end
    end
    for (int c = 0; c < 32; c++) begin
      if (cam_active[c]) begin
        if (cam_seen_ok[c] && (now - cam_seen[c]) < cam_cooldown) keep[c] = 1'b1;
        else off[c] = 1'b1;
      end
    end
    for (int i = 0; i < ncam; i++) begin
      if (det[i] && !keep[i]) begin
        if (pop_count(keep) < cam_limit) begin
          keep[i] = 1'b1;
          on[i] = 1'b1;
        end else begin
          best = '0;
          victim = -1;
          for (int c = 0; c < 32; c++) begin
            if (keep[c] && cam_seen_ok[c]) begin
              age = now - cam_seen[c];
              if (age > best) begin
                best = age;
                victim = c;
              end
            end
          end
          if (victim >= 0) begin
            keep[victim] = 1'b0;
            off[victim] = 1'b1;
            keep[i] = 1'b1;
            on[i] = 1'b1;
          end
        end
      end
    end
    cam_active = keep;
    r.active = keep;
    r.joined = on;
    r.dropped = off;
    r.changed = (on != 0) || (off != 0);
    return r;
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [ascd_pkg::DataW-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    stim_tbl.push_back(r);
  endtask

  task automatic add_batch(logic [ascd_pkg::MaskW-1:0] det, logic [ascd_pkg::TimeW-1:0] now,
                           bit typed, logic [ascd_pkg::MaskW-1:0] a,
                           logic [ascd_pkg::MaskW-1:0] on,
                           logic [ascd_pkg::MaskW-1:0] off, logic ch);
    stim_row_t r;
    r = '{default: '0};
    r.det = det;
    r.now = now;
    r.typed = typed;
    r.want = '{a, on, off, ch};
    stim_tbl.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ascd_pkg::DataW-1:0] data);
    start <= 1'b0;
    while (outcome_q.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ascd_pkg::REG_CAMERA_COUNT:  cam_count = data[5:0];
      ascd_pkg::REG_ACTIVE_LIMIT:  cam_limit = data[5:0];
      ascd_pkg::REG_COOLDOWN_TIME: cam_cooldown = data;
      default: ;
    endcase
  endtask

  task automatic send_batch(logic [ascd_pkg::MaskW-1:0] det,
                            logic [ascd_pkg::TimeW-1:0] now, bit typed,
                            outcome_t want);
    outcome_t got;
    start <= 1'b1;
    detect_mask <= det;
    now_time <= now;
    do @(posedge clk); while (busy);
    got = evaluate_batch(det, now);
    outcome_q.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (valid) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result active=%h", active_cams);
        end else begin
          outcome_t w;
          w = outcome_q.pop_front();
          if (w != {active_cams, activated_mask, deactivated_mask, changed}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %h/%h/%h/%b got %h/%h/%h/%b",
                       w.active, w.joined, w.dropped, w.changed, active_cams,
                       activated_mask, deactivated_mask, changed);
          end
        end
      end
    end
  end

  initial begin
    logic [ascd_pkg::TimeW-1:0] now;
    logic [ascd_pkg::MaskW-1:0] det;
    int unsigned                sent;
    int unsigned                pick;
    outcome_t                   none;
    none = '0;
    mismatches = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    detect_mask = '0;
    now_time = '0;
    cam_active = '0;
    for (int i = 0; i < 32; i++) begin
      cam_seen[i] = '0;
      cam_seen_ok[i] = 1'b0;
    end
    cam_count = 6'd25;
    cam_limit = 6'd4;
    cam_cooldown = 32'd5000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_batch(32'h0, 32'd0, 1, 32'h0, 32'h0, 32'h0, 1'b0);
    add_batch(32'hF, 32'd100, 1, 32'hF, 32'hF, 32'h0, 1'b1);
    add_batch(32'hFFFFFFFF, 32'd200, 1, 32'hF, 32'h0, 32'h0, 1'b0);
    add_batch(32'h10, 32'd300, 1, 32'h1E, 32'h10, 32'h1, 1'b1);
    add_batch(32'h0, 32'd5300, 1, 32'h0, 32'h0, 32'h1E, 1'b1);
    add_cfg(ascd_pkg::REG_COOLDOWN_TIME, 32'd0);
    add_batch(32'h3, 32'd6000, 1, 32'h3, 32'h3, 32'h0, 1'b1);
    add_batch(32'h1, 32'd6001, 1, 32'h1, 32'h1, 32'h3, 1'b1);
    add_cfg(ascd_pkg::REG_COOLDOWN_TIME, 32'hFFFFFFFF);
    add_cfg(ascd_pkg::REG_ACTIVE_LIMIT, 32'd0);
    add_batch(32'h4, 32'd6002, 1, 32'h4, 32'h4, 32'h1, 1'b1);
    add_cfg(ascd_pkg::REG_ACTIVE_LIMIT, 32'd63);
    add_batch(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h01FFFFFF, 32'h01FFFFFB, 32'h0, 1'b1);
    add_cfg(ascd_pkg::REG_CAMERA_COUNT, 32'd0);
    add_batch(32'hFFFFFFFF, 32'd0, 1, 32'h01FFFFFF, 32'h0, 32'h0, 1'b0);
    add_cfg(ascd_pkg::REG_CAMERA_COUNT, 32'd63);
    add_batch(32'hFFFFFFFF, 32'd5, 1, 32'hFFFFFFFF, 32'hFE000000, 32'h0, 1'b1);
    add_cfg(REG_UNUSED, 32'd0);
    add_cfg(ascd_pkg::REG_ACTIVE_LIMIT, 32'd2);
    add_batch(32'h0, 32'd10, 1, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0);
    add_batch(32'h80000000, 32'd11, 0, none.active, none.joined, none.dropped, 1'b0);
    add_cfg(ascd_pkg::REG_COOLDOWN_TIME, 32'd3);
    add_batch(32'h1, 32'd18, 0, none.active, none.joined, none.dropped, 1'b0);
    add_cfg(ascd_pkg::REG_CAMERA_COUNT, 32'd1);
    add_batch(32'h3, 32'd19, 0, none.active, none.joined, none.dropped, 1'b0);
    add_cfg(ascd_pkg::REG_CAMERA_COUNT, 32'd25);
    add_cfg(ascd_pkg::REG_ACTIVE_LIMIT, 32'd4);
    add_cfg(ascd_pkg::REG_COOLDOWN_TIME, 32'd5000);

    foreach (stim_tbl[k]) begin
      if (stim_tbl[k].is_cfg) write_reg(stim_tbl[k].idx, stim_tbl[k].data);
      else send_batch(stim_tbl[k].det, stim_tbl[k].now, stim_tbl[k].typed, stim_tbl[k].want);
    end

    sent = 0;
    now = 32'd20;
    while (sent < RandItems) begin
      pick = $urandom_range(0, 5);
      write_reg(ascd_pkg::REG_CAMERA_COUNT, pick == 0 ? 32'd0 : pick == 1 ? 32'd32 :
                pick == 2 ? 32'd63 : pick == 3 ? 32'd1 : $urandom_range(2, 32));
      pick = $urandom_range(0, 5);
      write_reg(ascd_pkg::REG_ACTIVE_LIMIT, pick == 0 ? 32'd0 : pick == 1 ? 32'd32 :
                pick == 2 ? 32'd63 : $urandom_range(1, 8));
      pick = $urandom_range(0, 6);
      write_reg(ascd_pkg::REG_COOLDOWN_TIME, pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFFFFFF :
                pick == 2 ? 32'd1 : $urandom_range(100, 8000));
      if ($urandom_range(0, 3) == 0) now = $urandom_range(32'hFFFF0000, 32'hFFFFFFFF);
      if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom);
      for (int j = 0; j < 100 && sent < RandItems; j++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) det = $urandom & $urandom & $urandom;
        else if (pick < 8) det = 32'h1 << $urandom_range(0, 31);
        else if (pick == 8) det = $urandom;
        else det = 32'h0;
        pick = $urandom_range(0, 19);
        if (pick == 0) now = $urandom;
        else if (pick < 4) now = now;
        else now = now + $urandom_range(1, 2500);
        if (sent < RandItems - CalmItems && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        send_batch(det, now, 0, none);
        sent++;
      end
    end
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
